### src/assert_macros.svh
// Assertion macros for the byte stream hash RTL, used by bsh_absorb.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### src/bsh_pkg.sv
// Package for the byte stream hash core: mode codes, seeds and hash functions.
// Used by bsh_absorb, bsh_finish and the top level.
`timescale 1ns / 1ps
`default_nettype none
package bsh_pkg;

    localparam int unsigned HashWidth = 32;

    localparam logic MODE_OAAT = 1'b0;
    localparam logic MODE_FNV  = 1'b1;

    localparam logic [HashWidth-1:0] OAAT_SEED = 32'h0000_0000;
    localparam logic [HashWidth-1:0] FNV_SEED  = 32'd2166136261;
    localparam logic [HashWidth-1:0] FNV_PRIME = 32'd16777619;

    typedef logic [HashWidth-1:0] t_hash;

    typedef struct packed {
        t_hash hash;
        logic  mode;
    } t_fin;

    function automatic t_hash oaat_byte(input t_hash h_in, input logic [7:0] b);
        t_hash h;
        h = h_in + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    function automatic t_hash fnv_byte(input t_hash h_in, input logic [7:0] b);
        t_hash h;
        h = h_in ^ {24'd0, b};
        h = h * FNV_PRIME;
        return h;
    endfunction

    function automatic t_hash oaat_finish(input t_hash h_in);
        t_hash h;
        h = h_in + (h_in << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    function automatic t_hash fnv_finish(input t_hash h_in);
        t_hash h;
        h = h_in + (h_in << 13);
        h = h ^ (h >> 7);
        h = h + (h << 3);
        h = h ^ (h >> 17);
        h = h + (h << 5);
        return h;
    endfunction

endpackage
`default_nettype wire

### src/byte_stream_hash_oaat_fnv_core.sv
// Top level of the byte stream hash core: mode register and stage wiring.
// Depends on bsh_pkg, bsh_absorb and bsh_finish.
//
// The core hashes a message that arrives one byte per input transaction and
// returns one 32-bit hash per message, on the transaction marked by tlast.
// The mode register selects Jenkins one-at-a-time (0) or FNV-1a with a final
// mix (1); it is sampled as each transaction is taken, and it should be
// written only while the core is idle. A transaction with tuser low adds no
// byte, so a lone such transaction with tlast high hashes the empty message.
// The core takes one transaction every clock cycle while the output is
// drained. A closing transaction's hash moves from the input register
// through the byte absorb stage, which loads the finish register, and the
// finish mix, which loads the output register.
`timescale 1ns / 1ps
`default_nettype none
module byte_stream_hash_oaat_fnv_core
    import bsh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,     // algorithm_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // byte_present
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // hash_value
);

    logic  r_mode;
    logic  w_fin_valid;
    logic  w_fin_ready;
    t_fin  w_fin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OAAT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    bsh_absorb u_absorb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_present   (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .i_fin_ready (w_fin_ready)
    );

    bsh_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .i_fin       (w_fin),
        .o_fin_ready (w_fin_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_hash      (m_axis_tdata)
    );

endmodule
`default_nettype wire

### src/bsh_absorb.sv
// Input register and per-byte absorb stage holding the running hash.
// Depends on bsh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bsh_absorb
    import bsh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_mode,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_present,
    input  wire logic       i_last,
    output logic            o_fin_valid,
    output t_fin            o_fin,
    input  wire logic       i_fin_ready
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_present;
    logic       r_in_last;
    logic       r_in_mode;
    t_hash      r_hash;
    logic       r_open;
    logic       r_fin_valid;
    t_fin       r_fin;

    t_hash      w_start;
    t_hash      n_hash;
    logic       w_fin_free;
    logic       w_adv;

    assign w_fin_free = !r_fin_valid || i_fin_ready;
    assign w_adv      = r_in_valid && (!r_in_last || w_fin_free);
    assign o_ready    = !r_in_valid || w_adv;

    always_comb begin
        if (r_open) begin
            w_start = r_hash;
        end else if (r_in_mode == MODE_FNV) begin
            w_start = FNV_SEED;
        end else begin
            w_start = OAAT_SEED;
        end
        if (!r_in_present) begin
            n_hash = w_start;
        end else if (r_in_mode == MODE_FNV) begin
            n_hash = fnv_byte(w_start, r_in_byte);
        end else begin
            n_hash = oaat_byte(w_start, r_in_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_open      <= 1'b0;
            r_hash      <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                if (r_in_last) begin
                    r_open <= 1'b0;
                    r_hash <= '0;
                end else begin
                    r_open <= 1'b1;
                    r_hash <= n_hash;
                end
            end
            if (w_fin_free) begin
                r_fin_valid <= w_adv && r_in_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte    <= i_byte;
            r_in_present <= i_present;
            r_in_last    <= i_last;
            r_in_mode    <= i_mode;
        end
        if (w_adv && r_in_last) begin
            r_fin.hash <= n_hash;
            r_fin.mode <= r_in_mode;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    `ASSERT_CLK(a_last_closes, i_clk, i_rst_n, (w_adv && r_in_last) |=> (!r_open && r_hash == '0))
    `ASSERT_CLK(a_body_opens, i_clk, i_rst_n, (w_adv && !r_in_last) |=> r_open)
    `ASSERT_CLK(a_fin_holds, i_clk, i_rst_n, (r_fin_valid && !i_fin_ready) |=> (r_fin_valid && $stable(r_fin)))
    `ASSERT_NEVER(a_closed_hash_zero, i_clk, i_rst_n, !r_open && r_hash != '0)

endmodule
`default_nettype wire

### src/bsh_finish.sv
// Finish mix stage and output register of the byte stream hash core.
// Depends on bsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsh_finish
    import bsh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fin_valid,
    input  wire t_fin  i_fin,
    output logic       o_fin_ready,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_hash      o_hash
);

    logic  r_out_valid;
    t_hash r_out_hash;
    t_hash n_out_hash;

    assign o_fin_ready = !r_out_valid || i_ready;

    always_comb begin
        if (i_fin.mode == MODE_FNV) begin
            n_out_hash = fnv_finish(i_fin.hash);
        end else begin
            n_out_hash = oaat_finish(i_fin.hash);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_out_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid && o_fin_ready) begin
            r_out_hash <= n_out_hash;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hash  = r_out_hash;

endmodule
`default_nettype wire

### dv/byte_stream_hash_oaat_fnv_checker.sv
// Checker for the byte stream hash core: watches the mode write, input and output streams.
// Predicts each message hash (one-at-a-time or FNV-1a) and compares it with the core output.
// Depends on bsh_pkg for the mode codes.
`timescale 1ns / 1ps
module byte_stream_hash_oaat_fnv_checker
    import bsh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_in_tvalid,
    input  wire logic        i_in_tready,
    input  wire logic [7:0]  i_in_tdata,     // data_byte
    input  wire logic        i_in_tuser,     // byte_present
    input  wire logic        i_in_tlast,     // last_byte
    input  wire logic        i_out_tvalid,
    input  wire logic        i_out_tready,
    input  wire logic [31:0] i_out_tdata,    // hash_value
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [31:0] JENKINS_START = 32'd0;
    localparam logic [31:0] FNV_OFFSET    = 32'd2166136261;
    localparam logic [31:0] FNV_MULT      = 32'd16777619;

    logic        mode_now     = MODE_OAAT;
    logic        msg_open     = 1'b0;
    logic [31:0] partial_hash = 32'd0;
    logic [31:0] hash_fifo[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] jenkins_absorb(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] t;
        t = acc + {24'd0, b};
        t = t + {t[21:0], 10'd0};
        return t ^ {6'd0, t[31:6]};
    endfunction

    function automatic logic [31:0] jenkins_close(input logic [31:0] acc);
        logic [31:0] t;
        t = acc + {acc[28:0], 3'd0};
        t = t ^ {11'd0, t[31:11]};
        return t + {t[16:0], 15'd0};
    endfunction

    function automatic logic [31:0] fnv_absorb(input logic [31:0] acc, input logic [7:0] b);
        logic [63:0] prod;
        prod = {32'd0, acc ^ {24'd0, b}} * {32'd0, FNV_MULT};
        return prod[31:0];
    endfunction

    function automatic logic [31:0] fnv_close(input logic [31:0] acc);
        logic [31:0] t;
        t = acc + {acc[18:0], 13'd0};
        t = t ^ {7'd0, t[31:7]};
        t = t + {t[28:0], 3'd0};
        t = t ^ {17'd0, t[31:17]};
        return t + {t[26:0], 5'd0};
    endfunction

    always @(posedge i_clk) begin : track
        logic [31:0] h;
        logic [31:0] want;
        if (!i_rst_n) begin
            mode_now     = MODE_OAAT;
            msg_open     = 1'b0;
            partial_hash = 32'd0;
            hash_fifo.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (hash_fifo.size() == 0) begin
                    $display("%0t: unexpected hash transaction, expected none, actual %08h",
                             $time, i_out_tdata);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = hash_fifo.pop_front();
                    if (i_out_tdata !== want) begin
                        $display("%0t: hash mismatch, expected %08h, actual %08h",
                                 $time, want, i_out_tdata);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                if (msg_open)
                    h = partial_hash;
                else
                    h = (mode_now == MODE_FNV) ? FNV_OFFSET : JENKINS_START;
                if (i_in_tuser)
                    h = (mode_now == MODE_FNV) ? fnv_absorb(h, i_in_tdata)
                                               : jenkins_absorb(h, i_in_tdata);
                if (i_in_tlast) begin
                    hash_fifo.push_back((mode_now == MODE_FNV) ? fnv_close(h) : jenkins_close(h));
                    msg_open     = 1'b0;
                    partial_hash = 32'd0;
                end else begin
                    msg_open     = 1'b1;
                    partial_hash = h;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                mode_now = i_cfg_data;
        end
        o_pending = hash_fifo.size();
    end

endmodule

### dv/byte_stream_hash_oaat_fnv_core_tb.sv
// Testbench top for byte_stream_hash_oaat_fnv_core: clock, reset, stimulus and verdict.
// Directed and random byte messages in both modes under several idle and stall mixes.
// Depends on bsh_pkg, the core RTL and byte_stream_hash_oaat_fnv_checker.
`timescale 1ns / 1ps
module byte_stream_hash_oaat_fnv_core_tb;
    import bsh_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 190;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_data    = MODE_OAAT;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;

    int fail_count;
    int pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    byte_stream_hash_oaat_fnv_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    byte_stream_hash_oaat_fnv_checker hash_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_in_tlast   (s_axis_tlast),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // A new hold request blocks the output for a long stretch while input keeps coming.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("byte_stream_hash_oaat_fnv_core_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent = items_sent + 1;
    endtask

    task automatic send_message();
        int n;
        n = int'(($urandom_range(0, 19) < 16) ? $urandom_range(1, 8) : $urandom_range(9, 40));
        for (int k = 0; k < n; k++)
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0, k == n - 1);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int  start;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One-at-a-time from reset: empty, extreme bytes, byte-less opening and closing items.
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        // Mode switched while a message is open.
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        drain_results();
        set_mode(MODE_FNV);
        send_item(8'h56, 1'b1, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        drain_results();
        set_mode(MODE_OAAT);
        send_item(8'h01, 1'b1, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                drain_results();
                set_mode(((ph + sub) % 2 == 0) ? MODE_OAAT : MODE_FNV);
                start = items_sent;
                while (items_sent - start < PHASE_ITEMS) begin
                    if (!hold_done && items_sent - start >= 40) begin
                        hold_req <= hold_req + 1;
                        hold_done = 1'b1;
                    end
                    send_message();
                end
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("byte_stream_hash_oaat_fnv_core_tb: PASS");
        else
            $display("byte_stream_hash_oaat_fnv_core_tb: FAIL");
        $finish;
    end

endmodule
